// ----- rtl/shs_pkg.sv -----
package shs_pkg;

  // Last byte position of a 64-byte block, last round of a compression
  localparam logic [5:0] SHS_LAST_BYTE  = 6'd63;
  localparam logic [5:0] SHS_LAST_ROUND = 6'd63;
  // Highest pending count that still leaves room for the length field
  localparam logic [5:0] SHS_PAD_LIMIT  = 6'd55;
  // Padding marker byte that follows the message
  localparam logic [7:0] SHS_MARK       = 8'h80;

  localparam int unsigned SHS_WORDS = 8;

  localparam logic [31:0] SHS_IV [SHS_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHS_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Source of the byte shifted into the block window
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_MSG,
    SEL_MARK,
    SEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic       shift_en;    // shift one byte into the block window
    byte_sel_e  sel;
    logic [2:0] len_idx;     // length byte position, most significant first
    logic       count_byte;  // advance the message byte count
    logic       work_load;   // load working variables from the chain
    logic       round_en;    // run one compression round
    logic [5:0] rnd;
    logic       fold;        // add working variables into the chain
    logic       out_load;    // move digest to output, restart the chain
  } shs_cmd_t;

  typedef struct packed {
    logic out_busy;
  } shs_sts_t;

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
// Channel   | Direction | tdata                                   | tuser        | tlast
// s_axis    | in        | [7:0] data_byte                         | byte_present | end_of_message
// m_axis    | out       | [31:0] digest_word, [34:32] word_index  | -            | last_word
//
// Message bytes are taken one per cycle while the controller waits for input.
// For a full block s_axis_tready stays low while the working variables are loaded,
// the 64 rounds run on the single round unit and the result is folded into the chain.
// At end of message the padding bytes go in one per cycle (64 - pending, or
// 128 - pending when more than 55 are pending); each block is compressed once full.
// Reset loads the initial hash values and clears the byte count.
// A stalled m_axis holds the next digest back only once a later one is finished.
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast
);

  shs_cmd_t cmd;
  shs_sts_t sts;

  // Sequence bytes, padding and rounds
  shs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_user_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Block window, round unit, chain state and digest output buffer
  shs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_byte_i     (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- rtl/shs_ctrl.sv -----
module shs_ctrl
  import shs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  logic     in_user_i,
  output logic     in_ready_o,
  input  shs_sts_t sts_i,
  output shs_cmd_t cmd_o
);

  localparam logic [2:0] ST_ACCEPT = 3'd0;
  localparam logic [2:0] ST_PAD80  = 3'd1;
  localparam logic [2:0] ST_PADZ   = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_COMP   = 3'd4;
  localparam logic [2:0] ST_FOLD   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [5:0] rnd_q, rnd_d;
  logic       pad_q, pad_d;
  logic       mark_q, mark_d;
  logic       len_blk_q, len_blk_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rnd_d      = rnd_q;
    pad_d      = pad_q;
    mark_d     = mark_q;
    len_blk_d  = len_blk_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_ZERO;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCEPT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_user_i) begin
            cmd_o.shift_en   = 1'b1;
            cmd_o.sel        = SEL_MSG;
            cmd_o.count_byte = 1'b1;
            cnt_d            = cnt_q + 6'd1;
          end
          if (in_user_i && (cnt_q == SHS_LAST_BYTE)) begin
            pad_d   = in_last_i;
            state_d = ST_LOAD;
          end else if (in_last_i) begin
            pad_d   = 1'b1;
            state_d = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.sel      = SEL_MARK;
        mark_d         = 1'b1;
        len_blk_d      = (cnt_q <= SHS_PAD_LIMIT);
        cnt_d          = cnt_q + 6'd1;
        state_d        = (cnt_q == SHS_LAST_BYTE) ? ST_LOAD : ST_PADZ;
      end
      ST_PADZ: begin
        cmd_o.shift_en = 1'b1;
        // length field fills the last eight bytes of the final block
        cmd_o.sel      = (len_blk_q && (cnt_q > SHS_PAD_LIMIT)) ? SEL_LEN : SEL_ZERO;
        cmd_o.len_idx  = cnt_q[2:0];
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == SHS_LAST_BYTE) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.work_load = 1'b1;
        rnd_d           = '0;
        state_d         = ST_COMP;
      end
      ST_COMP: begin
        cmd_o.round_en = 1'b1;
        cmd_o.rnd      = rnd_q;
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == SHS_LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (!pad_q) begin
          state_d = ST_ACCEPT;
        end else if (!mark_q) begin
          state_d = ST_PAD80;
        end else if (len_blk_q) begin
          state_d = ST_DONE;
        end else begin
          len_blk_d = 1'b1;
          state_d   = ST_PADZ;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          pad_d          = 1'b0;
          mark_d         = 1'b0;
          len_blk_d      = 1'b0;
          state_d        = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACCEPT;
      cnt_q     <= '0;
      rnd_q     <= '0;
      pad_q     <= 1'b0;
      mark_q    <= 1'b0;
      len_blk_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rnd_q     <= rnd_d;
      pad_q     <= pad_d;
      mark_q    <= mark_d;
      len_blk_q <= len_blk_d;
    end
  end

  a_comp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && rnd_q == SHS_LAST_ROUND) |=> state_q == ST_FOLD)
    else $error("compression did not end after the last round");

  a_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> cnt_q == '0)
    else $error("compression started on a partial block");

  a_done_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> (cnt_q == '0 && mark_q && len_blk_q && pad_q))
    else $error("digest ready without complete padding");

endmodule

// ----- rtl/shs_dp.sv -----
module shs_dp
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  shs_cmd_t    cmd_i,
  output shs_sts_t    sts_o,
  input  logic [7:0]  in_byte_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [511:0] win_q, win_d;
  logic [31:0]  wk_q [SHS_WORDS];
  logic [31:0]  chain_q [SHS_WORDS];
  logic [31:0]  out_q [SHS_WORDS];
  logic [2:0]   out_idx_q;
  logic         out_vld_q;
  logic [60:0]  msg_bytes_q;

  logic [7:0]   byte_mux;
  logic [63:0]  total_bits;
  logic [63:0]  len_shift;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  s0, s1, big_s0, big_s1, ch, maj, t1, t2;
  logic         out_take;

  assign total_bits = {msg_bytes_q, 3'b000};
  assign len_shift  = total_bits >> {~cmd_i.len_idx, 3'b000};

  always_comb begin
    case (cmd_i.sel)
      SEL_MSG:  byte_mux = in_byte_i;
      SEL_MARK: byte_mux = SHS_MARK;
      SEL_LEN:  byte_mux = len_shift[7:0];
      default:  byte_mux = '0;
    endcase
  end

  // Message schedule: window word 0 is W[t], new word W[t+16] enters at the bottom
  assign w0    = win_q[511:480];
  assign w1    = win_q[479:448];
  assign w9    = win_q[223:192];
  assign w14   = win_q[63:32];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  always_comb begin
    win_d = win_q;
    if (cmd_i.shift_en) begin
      win_d = {win_q[503:0], byte_mux};
    end else if (cmd_i.round_en) begin
      win_d = {win_q[479:0], w_new};
    end
  end

  assign big_s1 = rotr(wk_q[4], 6) ^ rotr(wk_q[4], 11) ^ rotr(wk_q[4], 25);
  assign big_s0 = rotr(wk_q[0], 2) ^ rotr(wk_q[0], 13) ^ rotr(wk_q[0], 22);
  assign ch     = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
  assign maj    = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
  assign t1     = wk_q[7] + big_s1 + ch + SHS_K[cmd_i.rnd] + w0;
  assign t2     = big_s0 + maj;

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.work_load) begin
      for (int j = 0; j < SHS_WORDS; j++) begin
        wk_q[j] <= chain_q[j];
      end
    end else if (cmd_i.round_en) begin
      wk_q[0] <= t1 + t2;
      wk_q[1] <= wk_q[0];
      wk_q[2] <= wk_q[1];
      wk_q[3] <= wk_q[2];
      wk_q[4] <= wk_q[3] + t1;
      wk_q[5] <= wk_q[4];
      wk_q[6] <= wk_q[5];
      wk_q[7] <= wk_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_bytes_q <= '0;
      for (int j = 0; j < SHS_WORDS; j++) begin
        chain_q[j] <= SHS_IV[j];
      end
    end else begin
      if (cmd_i.out_load) begin
        msg_bytes_q <= '0;
        for (int j = 0; j < SHS_WORDS; j++) begin
          chain_q[j] <= SHS_IV[j];
        end
      end else begin
        if (cmd_i.count_byte) begin
          msg_bytes_q <= msg_bytes_q + 61'd1;
        end
        if (cmd_i.fold) begin
          for (int j = 0; j < SHS_WORDS; j++) begin
            chain_q[j] <= chain_q[j] + wk_q[j];
          end
        end
      end
    end
  end

  // Output buffer: drain the digest one word per handshake
  assign out_take = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int j = 0; j < SHS_WORDS; j++) begin
        out_q[j] <= chain_q[j];
      end
    end else if (out_take) begin
      for (int j = 0; j < SHS_WORDS - 1; j++) begin
        out_q[j] <= out_q[j+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_idx_q <= '0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
      out_idx_q <= '0;
    end else if (out_take) begin
      out_idx_q <= out_idx_q + 3'd1;
      if (out_idx_q == 3'd7) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_busy = out_vld_q;
  assign m_axis_tvalid  = out_vld_q;
  assign m_axis_tdata   = {5'b00000, out_idx_q, out_q[0]};
  assign m_axis_tlast   = (out_idx_q == 3'd7);

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_vld_q)
    else $error("digest loaded while output still busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output still valid after the last digest word");

  a_shift_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.shift_en && cmd_i.round_en))
    else $error("byte shift and round in the same cycle");

endmodule

// ----- sim/shs_digest_checker.sv -----
`timescale 1ns / 1ps

module shs_digest_checker
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,        // [7:0] data_byte
  input  logic        s_tuser_i,        // [0] byte_present
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,        // [31:0] digest_word, [34:32] word_index
  input  logic        m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned words_open_o,
  output int unsigned words_checked_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [7:0]   msg_block [64];
  logic [5:0]   fill_cnt;
  logic [63:0]  hashed_bits;
  logic [31:0]  chain_h [SHS_WORDS];
  digest_word_t digest_q [$];
  int unsigned  fail_cnt;
  int unsigned  checked_cnt;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Load the initial hash values and forget any partial message
  function automatic void restart_chain();
    foreach (chain_h[i]) chain_h[i] = SHS_IV[i];
    fill_cnt    = '0;
    hashed_bits = '0;
  endfunction

  // Fold the 64 bytes of msg_block into the chain, full schedule up front
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + SHS_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    fail_cnt++;
    $display("%0t: %s: got %h, expected %h", $time, what, got, want_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t want;
    logic [63:0]  total_bits;
    if (!rst_ni) begin
      restart_chain();
      digest_q.delete();
      fail_cnt    = 0;
      checked_cnt = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i) begin
          msg_block[fill_cnt] = s_tdata_i;
          if (fill_cnt == SHS_LAST_BYTE) begin
            compress_block();
            hashed_bits += 64'd512;
            fill_cnt = '0;
          end else begin
            fill_cnt++;
          end
        end
        if (s_tlast_i) begin
          // Pad: marker, zeros, spill block if the length no longer fits
          msg_block[fill_cnt] = SHS_MARK;
          for (int i = int'(fill_cnt) + 1; i < 64; i++) msg_block[i] = '0;
          if (fill_cnt > SHS_PAD_LIMIT) begin
            compress_block();
            foreach (msg_block[i]) msg_block[i] = '0;
          end
          total_bits = hashed_bits + {55'd0, fill_cnt, 3'b000};
          for (int i = 0; i < 8; i++) msg_block[56+i] = total_bits[63-8*i -: 8];
          compress_block();
          for (int i = 0; i < SHS_WORDS; i++) begin
            want.word  = chain_h[i];
            want.index = 3'(i);
            want.last  = (i == SHS_WORDS - 1);
            digest_q.push_back(want);
          end
          restart_chain();
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (digest_q.size() == 0) begin
          report_mismatch("digest word with none expected", m_tdata_i[31:0], '0);
        end else begin
          want = digest_q.pop_front();
          if (m_tdata_i[31:0] !== want.word)
            report_mismatch("digest_word", m_tdata_i[31:0], want.word);
          if (m_tdata_i[34:32] !== want.index)
            report_mismatch("word_index", 32'(m_tdata_i[34:32]), 32'(want.index));
          if (m_tlast_i !== want.last)
            report_mismatch("last_word", 32'(m_tlast_i), 32'(want.last));
          if (m_tdata_i[39:35] !== '0)
            report_mismatch("unused tdata bits", 32'(m_tdata_i[39:35]), '0);
          checked_cnt++;
        end
      end
    end
    fail_count_o    <= fail_cnt;
    words_open_o    <= digest_q.size();
    words_checked_o <= checked_cnt;
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RUN_ITEMS    = 380;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 150;
  // Message lengths around the padding limit and block boundaries
  localparam int unsigned CORNER_LENS [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Set while both sides run without idling
  bit          steady = 1'b0;

  int unsigned items_sent;
  int unsigned msgs_sent;
  int unsigned bytes_sent;
  int unsigned longest_msg;
  int unsigned cycle_cnt;
  int unsigned fail_count;
  int unsigned words_open;
  int unsigned words_checked;

  sha256_stream_hasher i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  shs_digest_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .s_tlast_i       (s_axis_tlast),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .fail_count_o    (fail_count),
    .words_open_o    (words_open),
    .words_checked_o (words_checked)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Stall the digest side with a chance of about 27 percent, never while steady
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 27);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic push_item(input logic [7:0] data, input logic present, input logic eom);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 27) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    if (present || eom) items_sent++;
    if (present) bytes_sent++;
    if (eom) msgs_sent++;
  endtask

  // Random message; the end flag rides on the last byte or on an empty item
  task automatic send_message(input int unsigned len, input bit end_on_byte);
    bit fold_end;
    for (int unsigned i = 0; i < len; i++) begin
      // Sprinkle ignored items (no byte, no end) between bytes
      if (!steady && $urandom_range(0, 9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      fold_end = end_on_byte && (i == len - 1);
      push_item(8'($urandom), 1'b1, fold_end);
    end
    if (len == 0 || !end_on_byte) push_item(8'($urandom), 1'b0, 1'b1);
    if (len > longest_msg) longest_msg = len;
  endtask

  // Drop valid and hold off until every digest word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_open != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned len;
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored item, empty message, "abc", single bytes at both extremes
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'ha5, 1'b0, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    wait_drained();

    // Force a long tail and an exact full block ending on its last byte,
    // with both sides running flat out
    steady <= 1'b1;
    send_message(56, 1'($urandom));
    send_message(64, 1'b1);

    for (int unsigned k = 0; items_sent < RUN_ITEMS; k++) begin
      steady <= (k >= 3 && k < 6);
      pick = $urandom_range(0, 99);
      if (pick < 35) len = $urandom_range(0, 12);
      else if (pick < 60) len = CORNER_LENS[$urandom_range(0, 9)];
      else if (pick < 85) len = $urandom_range(0, 63);
      else len = $urandom_range(64, 150);
      send_message(len, 1'($urandom));
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    steady <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Hashed %0d messages, %0d bytes in all, longest %0d bytes;",
             msgs_sent, bytes_sent, longest_msg);
    $display("compared %0d digest words under random stalls on both sides.", words_checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/shs_pkg.sv
rtl/shs_ctrl.sv
rtl/shs_dp.sv
rtl/sha256_stream_hasher.sv
sim/shs_digest_checker.sv
sim/tb_top.sv
